FILE: rtl/lrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrb_pkg: shared types for the link reconnect backoff controller
// Beat payloads, register file contents, session state and mode codes.
// ----------------------------------------------------------------------------
package lrb_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_WAIT_LINK    = 3'd1,
        MODE_CONNECTING   = 3'd2,
        MODE_CONNECTED    = 3'd3,
        MODE_DISCONNECTED = 3'd4
    } lrb_mode_t;

    typedef enum logic [1:0] {
        REG_BACKOFF_START   = 2'd0,
        REG_BACKOFF_MAX     = 2'd1,
        REG_STATUS_INTERVAL = 2'd2
    } lrb_reg_idx_t;

    localparam logic KIND_BEGIN = 1'b0;

    localparam logic [15:0] BACKOFF_START_RST   = 16'd1000;
    localparam logic [15:0] BACKOFF_MAX_RST     = 16'd60000;
    localparam logic [15:0] STATUS_INTERVAL_RST = 16'd30000;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic        wifi_up;
        logic        connect_ok;
        logic        session_up;
    } lrb_in_t;

    typedef struct packed {
        logic [2:0]  link_mode;
        logic        connect_attempt;
        logic        subscribe_now;
        logic        retry_scheduled;
        logic [15:0] retry_delay;
        logic        service_session;
        logic        heartbeat_req;
    } lrb_out_t;

    typedef struct packed {
        logic [15:0] backoff_start;
        logic [15:0] backoff_max;
        logic [15:0] status_interval;
    } lrb_cfg_t;

    typedef struct packed {
        lrb_mode_t   mode;
        logic [31:0] next_attempt_time;
        logic [15:0] current_backoff;
        logic [31:0] last_status_time;
    } lrb_state_t;

endpackage : lrb_pkg
`default_nettype wire

FILE: rtl/lrb_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrb_cfg_regs: configuration register file
// Three 16-bit registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lrb_cfg_regs (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [15:0]           cfg_data,
    output lrb_pkg::lrb_cfg_t          cfg
);
    import lrb_pkg::*;

    lrb_cfg_t cfg_reg;
    lrb_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_BACKOFF_START:   cfg_next.backoff_start   = cfg_data;
                REG_BACKOFF_MAX:     cfg_next.backoff_max     = cfg_data;
                REG_STATUS_INTERVAL: cfg_next.status_interval = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.backoff_start   <= BACKOFF_START_RST;
            cfg_reg.backoff_max     <= BACKOFF_MAX_RST;
            cfg_reg.status_interval <= STATUS_INTERVAL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule : lrb_cfg_regs
`default_nettype wire

FILE: rtl/lrb_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrb_step: one controller step
// Next session state and result beat from the current state and one input.
// ----------------------------------------------------------------------------
module lrb_step (
    input  wire lrb_pkg::lrb_in_t      item,
    input  wire lrb_pkg::lrb_cfg_t     cfg,
    input  wire lrb_pkg::lrb_state_t   st,
    output lrb_pkg::lrb_state_t        st_next,
    output lrb_pkg::lrb_out_t          res
);
    import lrb_pkg::*;

    logic [31:0] due_diff;
    logic        due;
    logic [31:0] since_status;
    logic        publish_due;
    logic [15:0] retry_base;
    logic [16:0] doubled;
    logic [15:0] doubled_sat;

    // wrapping deadline test: now - deadline read as signed >= 0
    assign due_diff     = item.now_ms - st.next_attempt_time;
    assign due          = ~due_diff[31];
    assign since_status = item.now_ms - st.last_status_time;
    assign publish_due  = since_status >= {16'd0, cfg.status_interval};

    // session loss restarts the backoff before the retry is planned
    assign retry_base  = (st.mode == MODE_CONNECTED) ? cfg.backoff_start
                                                     : st.current_backoff;
    assign doubled     = {retry_base, 1'b0};
    assign doubled_sat = (doubled > {1'b0, cfg.backoff_max}) ? cfg.backoff_max
                                                             : doubled[15:0];

    always_comb begin
        st_next = st;
        res     = '0;
        if (item.kind == KIND_BEGIN) begin
            if (st.mode == MODE_IDLE) begin
                st_next.mode = MODE_WAIT_LINK;
            end
        end else begin
            case (st.mode)
                MODE_WAIT_LINK: begin
                    if (item.wifi_up) begin
                        st_next.mode              = MODE_CONNECTING;
                        st_next.next_attempt_time = item.now_ms;
                    end
                end
                MODE_CONNECTING: begin
                    if (due) begin
                        res.connect_attempt = 1'b1;
                        if (item.connect_ok) begin
                            st_next.mode             = MODE_CONNECTED;
                            st_next.current_backoff  = cfg.backoff_start;
                            st_next.last_status_time =
                                item.now_ms - {16'd0, cfg.status_interval};
                            res.subscribe_now        = 1'b1;
                        end else begin
                            res.retry_scheduled       = 1'b1;
                            res.retry_delay           = retry_base;
                            st_next.mode              = MODE_DISCONNECTED;
                            st_next.next_attempt_time =
                                item.now_ms + {16'd0, retry_base};
                            st_next.current_backoff   = doubled_sat;
                        end
                    end
                end
                MODE_CONNECTED: begin
                    if (!item.wifi_up || !item.session_up) begin
                        res.retry_scheduled       = 1'b1;
                        res.retry_delay           = retry_base;
                        st_next.mode              = MODE_DISCONNECTED;
                        st_next.next_attempt_time = item.now_ms + {16'd0, retry_base};
                        st_next.current_backoff   = doubled_sat;
                    end else begin
                        res.service_session = 1'b1;
                        if (publish_due) begin
                            st_next.last_status_time = item.now_ms;
                            res.heartbeat_req        = 1'b1;
                        end
                    end
                end
                MODE_DISCONNECTED: begin
                    if (!item.wifi_up) begin
                        st_next.mode = MODE_WAIT_LINK;
                    end else if (due) begin
                        st_next.mode = MODE_CONNECTING;
                    end
                end
                default: begin
                    st_next = st;
                end
            endcase
        end
        res.link_mode = st_next.mode;
    end

endmodule : lrb_step
`default_nettype wire

FILE: rtl/link_reconnect_backoff_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm: link session controller with reconnect backoff
// Five-mode session controller with doubling, saturating retry delay.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one beat per begin request or time tick (lrb_in_t).
//   m_ channel: exactly one result beat per input beat, in order (lrb_out_t).
//   cfg channel: register writes (backoff_start, backoff_max,
//   status_interval); always ready, to be used only while the block is idle.
// Timing
//   A beat accepted from the s_ channel is captured in the input register,
//   stepped through the controller logic and lands in the result register
//   once that register is free or draining.
//   One beat per cycle sustained while m_ready stays high; the bound is the
//   single session-state register, updated once per stepped beat.
// Reset
//   aresetn (synchronous, low) empties both pipeline registers, puts the
//   session in idle and restores the register file to its defaults.
// Stall
//   While m_ready is low the result register holds; one more beat may sit
//   in the input register, after which s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_fsm (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input beats
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lrb_pkg::lrb_in_t  s_data,
    // result beats
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lrb_pkg::lrb_out_t      m_data,
    // register writes
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);
    import lrb_pkg::*;

    lrb_cfg_t   cfg;

    // input register
    logic       in_valid_reg;
    lrb_in_t    in_data_reg;
    // result register
    logic       out_valid_reg;
    lrb_out_t   out_data_reg;
    // session state
    lrb_state_t st_reg;
    lrb_state_t st_next;
    lrb_out_t   res;

    logic       advance;

    lrb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lrb_step u_step (
        .item    (in_data_reg),
        .cfg     (cfg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res)
    );

    // step the held beat whenever the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= res;
        end
    end

    // session state: backoff restarts at its power-on default
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.mode              <= MODE_IDLE;
            st_reg.next_attempt_time <= '0;
            st_reg.current_backoff   <= BACKOFF_START_RST;
            st_reg.last_status_time  <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

endmodule : link_reconnect_backoff_fsm
`default_nettype wire

FILE: rtl/lrb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrb_checker: port-level checks for the link reconnect controller
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module lrb_checker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire lrb_pkg::lrb_out_t m_data
);
    import lrb_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_delay_only_on_retry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.retry_scheduled |-> m_data.retry_delay == 16'd0)
        else $error("retry delay without a scheduled retry");

    a_subscribe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.subscribe_now |->
            m_data.connect_attempt && m_data.link_mode == MODE_CONNECTED)
        else $error("subscribe without a successful attempt");

    a_retry_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.retry_scheduled |->
            m_data.link_mode == MODE_DISCONNECTED && !m_data.service_session)
        else $error("retry scheduled outside disconnected mode");

endmodule : lrb_checker

bind link_reconnect_backoff_fsm lrb_checker u_lrb_checker (.*);
`default_nettype wire

FILE: bench/lrb_session_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_session_checker: result checker for the link reconnect backoff controller
// Follows register writes and input beats, predicts the result beat of each
// input beat and compares accepted result beats with the oldest prediction.
// ----------------------------------------------------------------------------
module lrb_session_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  lrb_pkg::lrb_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  lrb_pkg::lrb_out_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output int                fail_count,
    output int                pending
);
    import lrb_pkg::*;

    lrb_cfg_t   regs;
    lrb_state_t sess;
    lrb_out_t   predicted_q[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Deadline reached when the wrapping difference reads as non-negative.
    function automatic logic deadline_passed(input logic [31:0] t, input logic [31:0] due);
        logic [31:0] diff;
        diff = t - due;
        return ~diff[31];
    endfunction

    task automatic advance_session(input lrb_in_t beat, output lrb_out_t res);
        logic [16:0] doubled;
        logic        retry;
        res   = '0;
        retry = 1'b0;
        if (beat.kind == KIND_BEGIN) begin
            if (sess.mode == MODE_IDLE)
                sess.mode = MODE_WAIT_LINK;
        end else begin
            case (sess.mode)
                MODE_WAIT_LINK: begin
                    if (beat.wifi_up) begin
                        sess.mode              = MODE_CONNECTING;
                        sess.next_attempt_time = beat.now_ms;
                    end
                end
                MODE_CONNECTING: begin
                    if (deadline_passed(beat.now_ms, sess.next_attempt_time)) begin
                        res.connect_attempt = 1'b1;
                        if (beat.connect_ok) begin
                            sess.mode             = MODE_CONNECTED;
                            sess.current_backoff  = regs.backoff_start;
                            sess.last_status_time = beat.now_ms - {16'd0, regs.status_interval};
                            res.subscribe_now     = 1'b1;
                        end else begin
                            retry = 1'b1;
                        end
                    end
                end
                MODE_CONNECTED: begin
                    if (!beat.wifi_up || !beat.session_up) begin
                        sess.current_backoff = regs.backoff_start;
                        retry                = 1'b1;
                    end else begin
                        res.service_session = 1'b1;
                        if (beat.now_ms - sess.last_status_time >=
                            {16'd0, regs.status_interval}) begin
                            sess.last_status_time = beat.now_ms;
                            res.heartbeat_req     = 1'b1;
                        end
                    end
                end
                MODE_DISCONNECTED: begin
                    if (!beat.wifi_up)
                        sess.mode = MODE_WAIT_LINK;
                    else if (deadline_passed(beat.now_ms, sess.next_attempt_time))
                        sess.mode = MODE_CONNECTING;
                end
                default: ;
            endcase
            if (retry) begin
                res.retry_scheduled    = 1'b1;
                res.retry_delay        = sess.current_backoff;
                sess.mode              = MODE_DISCONNECTED;
                sess.next_attempt_time = beat.now_ms + {16'd0, sess.current_backoff};
                doubled                = {sess.current_backoff, 1'b0};
                if (doubled > {1'b0, regs.backoff_max})
                    doubled = {1'b0, regs.backoff_max};
                sess.current_backoff   = doubled[15:0];
            end
        end
        res.link_mode = sess.mode;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        lrb_out_t want;
        lrb_out_t prediction;
        if (!aresetn) begin
            regs.backoff_start     = BACKOFF_START_RST;
            regs.backoff_max       = BACKOFF_MAX_RST;
            regs.status_interval   = STATUS_INTERVAL_RST;
            sess.mode              = MODE_IDLE;
            sess.next_attempt_time = '0;
            sess.current_backoff   = BACKOFF_START_RST;
            sess.last_status_time  = '0;
            predicted_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_q.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result beat expected none, got %h", $time, m_data);
                end else begin
                    want = predicted_q.pop_front();
                    check_field("link_mode", 32'(want.link_mode), 32'(m_data.link_mode));
                    check_field("connect_attempt", 32'(want.connect_attempt),
                                32'(m_data.connect_attempt));
                    check_field("subscribe_now", 32'(want.subscribe_now),
                                32'(m_data.subscribe_now));
                    check_field("retry_scheduled", 32'(want.retry_scheduled),
                                32'(m_data.retry_scheduled));
                    check_field("retry_delay", 32'(want.retry_delay),
                                32'(m_data.retry_delay));
                    check_field("service_session", 32'(want.service_session),
                                32'(m_data.service_session));
                    check_field("heartbeat_req", 32'(want.heartbeat_req),
                                32'(m_data.heartbeat_req));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BACKOFF_START:   regs.backoff_start   = cfg_data;
                    REG_BACKOFF_MAX:     regs.backoff_max     = cfg_data;
                    REG_STATUS_INTERVAL: regs.status_interval = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                advance_session(s_data, prediction);
                predicted_q.push_back(prediction);
            end
        end
        pending = predicted_q.size();
    end

endmodule

FILE: bench/tb_link_reconnect_backoff_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_link_reconnect_backoff_fsm: testbench for the reconnect backoff controller
// Directed session walk-through at reset settings, then random tick streams
// under a range of register settings with random gaps and result stalls.
// Checking is done by lrb_session_checker; this module only drives and judges.
// ----------------------------------------------------------------------------
module tb_link_reconnect_backoff_fsm;
    import lrb_pkg::*;

    localparam logic       KIND_TICK     = 1'b1;
    localparam logic [1:0] REG_SPARE_IDX = 2'd3;   // no register here, write is dropped
    localparam int         PHASE_ITEMS   = 150;
    localparam int         GAP_MAX       = 3;
    localparam logic [31:0] T0           = 32'hFFFF_FF00;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    lrb_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    lrb_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;

    // Stimulus state: running millisecond clock, spread of time steps for the
    // current settings, and the no-gap stretch flags of both sides.
    logic [31:0] clock_ms;
    int unsigned time_scale;
    logic        send_burst;
    logic        take_burst;

    always #4 aclk = ~aclk;

    link_reconnect_backoff_fsm u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lrb_session_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one input beat. Called at a falling edge, returns at the falling
    // edge after acceptance with valid still high, so back-to-back beats
    // never drop valid in between.
    task automatic send_item(input logic kind, input logic [31:0] now,
                             input logic wifi, input logic ok, input logic alive);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 31) == 0)
            send_burst = ~send_burst;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{kind: kind, now_ms: now, wifi_up: wifi, connect_ok: ok,
                     session_up: alive};
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Drop valid and hold off until every predicted result beat is out; the
    // block has one result per beat, so the pending count covers the pipe.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
    endtask

    // Settings change only with the block drained. A write to the spare
    // index follows each set and must leave the registers alone.
    task automatic apply_config(input logic [15:0] start, input logic [15:0] ceiling,
                                input logic [15:0] interval);
        drain_results();
        write_reg(REG_BACKOFF_START, start);
        write_reg(REG_BACKOFF_MAX, ceiling);
        write_reg(REG_STATUS_INTERVAL, interval);
        write_reg(REG_SPARE_IDX, 16'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
        time_scale = 16;
        if (32'(start) > time_scale) time_scale = 32'(start);
        if (32'(ceiling) > time_scale) time_scale = 32'(ceiling);
        if (32'(interval) > time_scale) time_scale = 32'(interval);
    endtask

    // Mostly well-formed ticks: time moves forward by steps on the scale of
    // the current delays, link and session mostly up, attempts succeed a bit
    // over half the time. The rest is stray begins, huge time jumps (which
    // read as the past under the signed compare) and fully random beats.
    task automatic random_item();
        int unsigned pick;
        int unsigned step;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            clock_ms = $urandom;
            send_item(1'($urandom_range(0, 1)), clock_ms, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick == 1) begin
            send_item(KIND_BEGIN, clock_ms, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4:  step = $urandom_range(0, 16);
                5, 6, 7, 8, 9:  step = $urandom_range(0, time_scale);
                10, 11, 12:     step = $urandom_range(time_scale / 2, time_scale * 2 + 1);
                13:             step = 0;
                14:             step = $urandom_range(0, 1 << 20);
                default:        step = $urandom;
            endcase
            clock_ms = clock_ms + step;
            send_item(KIND_TICK, clock_ms, $urandom_range(0, 9) != 0,
                      $urandom_range(0, 9) < 6, $urandom_range(0, 11) != 0);
        end
    endtask

    // Result side: a random stall before each beat is taken, with stall-free stretches.
    initial begin
        int stall;
        m_ready    = 1'b0;
        take_burst = 1'b0;
        @(negedge aclk);
        forever begin
            stall = take_burst ? 0 : $urandom_range(0, GAP_MAX);
            if ($urandom_range(0, 31) == 0)
                take_burst = ~take_burst;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // Watchdog, far beyond the slowest legal run (about 100 us).
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        aresetn    = 1'b0;
        send_burst = 1'b0;
        time_scale = 30000;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed walk-through at reset settings (1000 / 60000 / 30000)
        send_item(KIND_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);    // tick in idle: no effect
        send_item(KIND_TICK, 32'h0, 1'b0, 1'b0, 1'b0);
        send_item(KIND_BEGIN, 32'h0, 1'b0, 1'b0, 1'b0);           // leave idle
        send_item(KIND_BEGIN, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);   // begin outside idle: ignored
        send_item(KIND_TICK, 32'd10, 1'b0, 1'b1, 1'b1);           // lower link still down
        send_item(KIND_TICK, T0, 1'b1, 1'b0, 1'b0);               // link up, deadline = T0
        send_item(KIND_TICK, T0 - 1, 1'b1, 1'b1, 1'b1);           // not due, connect_ok dropped
        send_item(KIND_TICK, T0 + 32'h8000_0000, 1'b1, 1'b1, 1'b1); // half range reads as past
        send_item(KIND_TICK, T0 + 32'h200, 1'b1, 1'b0, 1'b1);     // fails across the wrap
        send_item(KIND_TICK, 32'h0000_0200, 1'b1, 1'b1, 1'b1);    // backing off, not due
        send_item(KIND_TICK, 32'h0000_04E8, 1'b1, 1'b1, 1'b1);    // due exactly
        send_item(KIND_TICK, 32'h0000_04E8, 1'b1, 1'b0, 1'b1);    // second failure, doubled
        send_item(KIND_TICK, 32'h0000_0500, 1'b0, 1'b0, 1'b0);    // outage while backing off
        send_item(KIND_TICK, 32'h0000_0600, 1'b1, 1'b0, 1'b0);
        send_item(KIND_TICK, 32'h0000_0600, 1'b1, 1'b1, 1'b0);    // connect succeeds
        send_item(KIND_TICK, 32'h0000_0600, 1'b1, 1'b1, 1'b1);    // first service publishes
        send_item(KIND_TICK, 32'h0000_0601, 1'b1, 1'b0, 1'b1);
        send_item(KIND_TICK, 32'h0000_0600 + 30000, 1'b1, 1'b0, 1'b1); // exactly one interval
        send_item(KIND_TICK, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);    // session lost
        send_item(KIND_TICK, 32'h8000_03E7, 1'b1, 1'b0, 1'b1);    // due across sign boundary
        send_item(KIND_TICK, 32'h8000_03E7, 1'b1, 1'b1, 1'b1);
        send_item(KIND_TICK, 32'h8000_03E8, 1'b0, 1'b1, 1'b1);    // lower link lost, connected
        clock_ms = 32'h8000_1000;

        repeat (PHASE_ITEMS) random_item();

        // --- random streams under several settings, extremes first
        apply_config(16'd1, 16'd65535, 16'd1);        // tiny start, widest ceiling
        repeat (PHASE_ITEMS) random_item();
        apply_config(16'd65535, 16'd1, 16'd65535);    // start above ceiling
        repeat (PHASE_ITEMS) random_item();
        apply_config(16'd0, 16'd40000, 16'd0);        // zero delays, publish every service
        repeat (PHASE_ITEMS) random_item();
        apply_config(16'd40000, 16'd65535, 16'd20000); // doubling overflows 16 bits
        repeat (PHASE_ITEMS) random_item();
        apply_config(16'd50, 16'd3000, 16'd500);
        repeat (PHASE_ITEMS) random_item();
        apply_config(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 65535)),
                     16'($urandom_range(1, 65535)));
        repeat (PHASE_ITEMS) random_item();
        apply_config(BACKOFF_START_RST, BACKOFF_MAX_RST, STATUS_INTERVAL_RST);
        repeat (PHASE_ITEMS) random_item();
        apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
        repeat (PHASE_ITEMS) random_item();

        drain_results();
        repeat (4) @(negedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
